FILE: rtl/rbr_pkg.sv
package rbr_pkg;

  // Default sizing
  localparam int RBR_MAX_RAY_BINS = 4096;
  localparam int RBR_MAX_RUN      = 33;

  // Field and register widths
  localparam int RBR_SMP_W = 16;
  localparam int RBR_WGT_W = 16;
  localparam int RBR_SUM_W = 32;
  localparam int RBR_CFG_W = 16;
  localparam int RBR_CFG_AW = 2;

  // Shared divider: 34-bit dividend, 17-bit divisor, one quotient bit per cycle
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = $clog2(DIV_NW);

  // Register reset values
  localparam logic [RBR_CFG_W-1:0] RST_NODATA   = 16'hFFFF;
  localparam logic [RBR_CFG_W-1:0] RST_UNDETECT = 16'h0000;
  localparam logic [RBR_CFG_W-1:0] RST_IN_LEN   = 16'd250;
  localparam logic [RBR_CFG_W-1:0] RST_OUT_LEN  = 16'd1000;

  // Mean clamp limits
  localparam logic [RBR_SMP_W-1:0] VAL_MIN = 16'd1;
  localparam logic [RBR_SMP_W-1:0] VAL_MAX = 16'd65534;

  typedef enum logic [RBR_CFG_AW-1:0] {
    CFG_NODATA,
    CFG_UNDETECT,
    CFG_IN_LEN,
    CFG_OUT_LEN
  } rbr_cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_NODATA,
    CLS_UNDET,
    CLS_VALID
  } rbr_cls_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_TGT,
    ST_SCAN,
    ST_EVAL,
    ST_DIV,
    ST_WRITE,
    ST_TAIL,
    ST_OUT_RD,
    ST_OUT_SHOW
  } rbr_state_t;

  // Divider request
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } rbr_div_req_t;

  // Divider response
  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } rbr_div_rsp_t;

  // One buffered result
  typedef struct packed {
    logic [RBR_SMP_W-1:0] value;
    logic                 ray_end;
  } rbr_res_t;

endpackage

FILE: rtl/rbr_in_if.sv
interface rbr_in_if
  import rbr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [RBR_SMP_W-1:0] sample;
  logic                 last_in_ray;

  modport source (output valid, output sample, output last_in_ray, input ready);
  modport sink (input valid, input sample, input last_in_ray, output ready);
endinterface

FILE: rtl/rbr_out_if.sv
interface rbr_out_if
  import rbr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [RBR_SMP_W-1:0] value;
  logic                 ray_end;
  logic                 run_last;
  logic                 dropped;

  modport source (
    output valid, output value, output ray_end, output run_last, output dropped,
    input ready
  );
  modport sink (
    input valid, input value, input ray_end, input run_last, input dropped,
    output ready
  );
endinterface

FILE: rtl/rbr_div.sv
module rbr_div
  import rbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  rbr_div_req_t req,
  output rbr_div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] num;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              fits;

  // Restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem, num[DIV_NW-1]};
    fits    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[DIV_NW-2:0], 1'b0};
      rem <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

FILE: rtl/rbr_buf.sv
module rbr_buf
  import rbr_pkg::*;
#(
  parameter  int DEPTH = RBR_MAX_RUN,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rbr_res_t      wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output rbr_res_t      rdata
);

  rbr_res_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/range_bin_resampler_unit.sv
// Operation: a ray's last sample first runs the 34-step shared divider for the bin count;
//   each output bin that needs a weighted mean runs it again, a bin decided by code does
//   not; the block is not ready until its results have gone out.
// Output: each result is read from the result buffer, then shown until taken; bins past
//   the per-input limit advance at one per cycle.
// Reset: synchronous rst restores register defaults and clears all ray state.
module range_bin_resampler_unit
  import rbr_pkg::*;
#(
  parameter int MAX_RAY_BINS = RBR_MAX_RAY_BINS,
  parameter int MAX_RUN      = RBR_MAX_RUN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RBR_CFG_AW-1:0] cfg_idx,
  input  logic [RBR_CFG_W-1:0]  cfg_data,
  rbr_in_if.sink                smp_ch,
  rbr_out_if.source             res_ch
);

  localparam int POS_W = $clog2(MAX_RAY_BINS) + 17;
  localparam int SCW   = $clog2(MAX_RAY_BINS + 1);
  localparam int RUN_W = $clog2(MAX_RUN + 1);
  localparam int AW    = $clog2(MAX_RUN);

  rbr_state_t state, state_next;

  // Configuration registers
  logic [RBR_CFG_W-1:0] nodata_code;
  logic [RBR_CFG_W-1:0] undetect_code;
  logic [RBR_CFG_W-1:0] in_bin_len;
  logic [RBR_CFG_W-1:0] out_bin_len;

  // Ray state
  logic [POS_W-1:0]     consumed_len;
  logic [POS_W-1:0]     out_start;
  logic [POS_W-1:0]     bin_count;
  logic [SCW-1:0]       sample_count;
  logic [RBR_WGT_W-1:0] valid_weight;
  logic [RBR_WGT_W-1:0] nodata_weight;
  logic [RBR_WGT_W-1:0] undetect_weight;
  logic [RBR_SUM_W-1:0] weighted_sum;

  // Per-item control
  logic             is_last;
  logic             in_tail;
  logic             drop;
  logic [RUN_W-1:0] run_n;
  logic [RUN_W-1:0] rd_idx;

  // Per-item payload
  logic [RBR_SMP_W-1:0] cur_smp;
  rbr_cls_t             cur_cls;
  logic [POS_W-1:0]     end_pos;
  logic [POS_W-1:0]     target;
  logic [RBR_SMP_W-1:0] val_reg;

  // Combinational helpers
  logic [RBR_CFG_W-1:0] len_in;
  logic [RBR_CFG_W-1:0] rlen;
  logic [POS_W-1:0]     hi;
  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     tail_from;
  logic                 bin_done;
  logic [RBR_WGT_W-1:0] seg_len;
  logic [RBR_WGT_W-1:0] tail_len;
  logic [RBR_SUM_W-1:0] seg_prod;
  logic                 run_full;
  logic                 more_bins;
  logic                 und_win;
  logic                 nd_win;
  logic                 need_div;
  logic [RBR_SMP_W-1:0] code_val;
  logic [RBR_SMP_W-1:0] mean_val;
  rbr_cls_t             in_cls;

  rbr_div_req_t div_req;
  rbr_div_rsp_t div_rsp;
  logic         buf_we;
  logic         buf_re;
  rbr_res_t     buf_wdata;
  rbr_res_t     buf_rdata;

  // Zero lengths act as one
  assign len_in = (in_bin_len == '0) ? RBR_CFG_W'(1) : in_bin_len;
  assign rlen   = (out_bin_len == '0) ? RBR_CFG_W'(1) : out_bin_len;

  // Classify the incoming sample; nodata is tested first
  always_comb begin
    if (smp_ch.sample == nodata_code) begin
      in_cls = CLS_NODATA;
    end else if (smp_ch.sample == undetect_code) begin
      in_cls = CLS_UNDET;
    end else begin
      in_cls = CLS_VALID;
    end
  end

  // Overlap of the current sample with the current output bin
  always_comb begin
    hi        = out_start + POS_W'(rlen);
    lo        = (consumed_len > out_start) ? consumed_len : out_start;
    bin_done  = hi <= end_pos;
    tail_from = (out_start > end_pos) ? out_start : end_pos;
    tail_len  = RBR_WGT_W'(hi - tail_from);
    if (bin_done) begin
      seg_len = (hi > lo) ? RBR_WGT_W'(hi - lo) : '0;
    end else begin
      seg_len = (end_pos > lo) ? RBR_WGT_W'(end_pos - lo) : '0;
    end
    seg_prod  = RBR_SUM_W'(seg_len) * RBR_SUM_W'(cur_smp);
    run_full  = run_n == RUN_W'(MAX_RUN);
    more_bins = bin_count < target;
  end

  // Bin decision
  always_comb begin
    und_win  = (undetect_weight > valid_weight) && (undetect_weight >= nodata_weight);
    nd_win   = (nodata_weight > valid_weight) && (nodata_weight > undetect_weight);
    need_div = !und_win && !nd_win && (valid_weight != '0);
    code_val = und_win ? undetect_code : nodata_code;
    if (div_rsp.quo == '0) begin
      mean_val = VAL_MIN;
    end else if (div_rsp.quo > DIV_NW'(VAL_MAX)) begin
      mean_val = VAL_MAX;
    end else begin
      mean_val = div_rsp.quo[RBR_SMP_W-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_next    = state;
    smp_ch.ready  = 1'b0;
    res_ch.valid  = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = (DIV_NW'(end_pos) << 1) + DIV_NW'(rlen);
    div_req.den   = {rlen, 1'b0};
    buf_we        = 1'b0;
    buf_re        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        smp_ch.ready = 1'b1;
        if (smp_ch.valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (is_last) begin
          div_req.start = 1'b1;
          state_next    = ST_TGT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_TGT: begin
        if (div_rsp.done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bin_done) begin
          state_next = run_full ? ST_SCAN : ST_EVAL;
        end else if (is_last) begin
          state_next = ST_TAIL;
        end else begin
          state_next = (run_n != '0) ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_EVAL: begin
        div_req.num = (DIV_NW'(weighted_sum) << 1) + DIV_NW'(valid_weight);
        div_req.den = {valid_weight, 1'b0};
        if (need_div) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        buf_we     = 1'b1;
        state_next = in_tail ? ST_TAIL : ST_SCAN;
      end
      ST_TAIL: begin
        if (more_bins && !run_full) begin
          state_next = ST_EVAL;
        end else begin
          state_next = (run_n != '0) ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_OUT_RD: begin
        buf_re     = 1'b1;
        state_next = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        res_ch.valid = 1'b1;
        if (res_ch.ready) begin
          state_next = (rd_idx == run_n - 1'b1) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nodata_code   <= RST_NODATA;
      undetect_code <= RST_UNDETECT;
      in_bin_len    <= RST_IN_LEN;
      out_bin_len   <= RST_OUT_LEN;
    end else if (cfg_we) begin
      unique case (rbr_cfg_idx_t'(cfg_idx))
        CFG_NODATA:   nodata_code   <= cfg_data;
        CFG_UNDETECT: undetect_code <= cfg_data;
        CFG_IN_LEN:   in_bin_len    <= cfg_data;
        CFG_OUT_LEN:  out_bin_len   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Ray state and per-item control
  always_ff @(posedge clk) begin
    if (rst) begin
      consumed_len    <= '0;
      out_start       <= '0;
      bin_count       <= '0;
      sample_count    <= '0;
      valid_weight    <= '0;
      nodata_weight   <= '0;
      undetect_weight <= '0;
      weighted_sum    <= '0;
      is_last         <= 1'b0;
      in_tail         <= 1'b0;
      drop            <= 1'b0;
      run_n           <= '0;
      rd_idx          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (smp_ch.valid) begin
            is_last <= smp_ch.last_in_ray ||
                       (sample_count == SCW'(MAX_RAY_BINS - 1));
            in_tail <= 1'b0;
            drop    <= 1'b0;
            run_n   <= '0;
            rd_idx  <= '0;
          end
        end
        ST_SCAN: begin
          if (bin_done && run_full) begin
            // result beyond the limit: advance without computing it
            drop            <= 1'b1;
            valid_weight    <= '0;
            nodata_weight   <= '0;
            undetect_weight <= '0;
            weighted_sum    <= '0;
            out_start       <= hi;
            bin_count       <= bin_count + 1'b1;
          end else begin
            case (cur_cls)
              CLS_NODATA: nodata_weight   <= nodata_weight + seg_len;
              CLS_UNDET:  undetect_weight <= undetect_weight + seg_len;
              default: begin
                valid_weight <= valid_weight + seg_len;
                weighted_sum <= weighted_sum + seg_prod;
              end
            endcase
            if (!bin_done) begin
              consumed_len <= end_pos;
              sample_count <= sample_count + 1'b1;
              in_tail      <= is_last;
            end
          end
        end
        ST_WRITE: begin
          valid_weight    <= '0;
          nodata_weight   <= '0;
          undetect_weight <= '0;
          weighted_sum    <= '0;
          out_start       <= hi;
          bin_count       <= bin_count + 1'b1;
          run_n           <= run_n + 1'b1;
        end
        ST_TAIL: begin
          if (more_bins && !run_full) begin
            // part of the bin past the ray end counts as nodata
            nodata_weight <= nodata_weight + tail_len;
          end else begin
            if (more_bins) begin
              drop <= 1'b1;
            end
            consumed_len    <= '0;
            out_start       <= '0;
            bin_count       <= '0;
            sample_count    <= '0;
            valid_weight    <= '0;
            nodata_weight   <= '0;
            undetect_weight <= '0;
            weighted_sum    <= '0;
          end
        end
        ST_OUT_SHOW: begin
          if (res_ch.ready) begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && smp_ch.valid) begin
      cur_smp <= smp_ch.sample;
      cur_cls <= in_cls;
      end_pos <= consumed_len + POS_W'(len_in);
    end
    if (state == ST_TGT && div_rsp.done) begin
      target <= div_rsp.quo[POS_W-1:0];
    end
    if (state == ST_EVAL) begin
      val_reg <= code_val;
    end
    if (state == ST_DIV && div_rsp.done) begin
      val_reg <= mean_val;
    end
  end

  // Result entry
  assign buf_wdata.value   = val_reg;
  assign buf_wdata.ray_end = is_last && (bin_count + 1'b1 == target);

  rbr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rbr_buf #(
    .DEPTH (MAX_RUN)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (run_n[AW-1:0]),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (buf_rdata)
  );

  // Output transfer fields
  assign res_ch.value    = buf_rdata.value;
  assign res_ch.ray_end  = buf_rdata.ray_end;
  assign res_ch.run_last = rd_idx == run_n - 1'b1;
  assign res_ch.dropped  = drop;

endmodule

FILE: tb/tb_range_bin_resampler_unit.sv
module tb_range_bin_resampler_unit;
  import rbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 5;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          SETTLE      = 200;
  localparam int          SEG_ITEMS   = 18;
  localparam int          SRC_IDLE[4] = '{0, 84, 0, 16};
  localparam int          SNK_STALL[4] = '{0, 0, 84, 16};
  localparam rbr_cfg_idx_t REG_ORDER[4] = '{CFG_NODATA, CFG_UNDETECT, CFG_IN_LEN, CFG_OUT_LEN};

  // One output bin as seen on the result channel
  typedef struct {
    logic [RBR_SMP_W-1:0] value;
    logic                 ray_end;
    logic                 run_last;
    logic                 dropped;
  } resampled_bin_t;

  // Re-binning predictor plus the queue of bins still owed by the block
  class resample_scoreboard;
    logic [RBR_CFG_W-1:0] nodata_code;
    logic [RBR_CFG_W-1:0] undetect_code;
    logic [RBR_CFG_W-1:0] in_len;
    logic [RBR_CFG_W-1:0] out_len;

    longint unsigned ray_pos;
    longint unsigned bin_start;
    longint unsigned ray_bin_count;
    int unsigned     samples_in_ray;
    int unsigned     valid_w;
    int unsigned     nodata_w;
    int unsigned     undet_w;
    int unsigned     valid_sum;

    // bookkeeping for the bins caused by one input
    resampled_bin_t  run_q[$];
    int unsigned     run_count;
    bit              run_drop;
    bit              run_closes_ray;
    longint unsigned run_target;

    resampled_bin_t  expected_q[$];
    int unsigned     results_checked;
    int unsigned     mismatches;

    function new();
      nodata_code     = RST_NODATA;
      undetect_code   = RST_UNDETECT;
      in_len          = RST_IN_LEN;
      out_len         = RST_OUT_LEN;
      results_checked = 0;
      mismatches      = 0;
      clear_ray();
    endfunction

    function void clear_weights();
      valid_w   = 0;
      nodata_w  = 0;
      undet_w   = 0;
      valid_sum = 0;
    endfunction

    function void clear_ray();
      ray_pos        = 0;
      bin_start      = 0;
      ray_bin_count  = 0;
      samples_in_ray = 0;
      clear_weights();
    endfunction

    function void write_reg(rbr_cfg_idx_t idx, logic [RBR_CFG_W-1:0] data);
      case (idx)
        CFG_NODATA:   nodata_code = data;
        CFG_UNDETECT: undetect_code = data;
        CFG_IN_LEN:   in_len = data;
        CFG_OUT_LEN:  out_len = data;
        default:      ;
      endcase
    endfunction

    function bit pending();
      return expected_q.size() != 0;
    endfunction

    function void add_weight(rbr_cls_t cls, logic [RBR_SMP_W-1:0] smp, longint unsigned len);
      case (cls)
        CLS_NODATA: nodata_w += 32'(len);
        CLS_UNDET:  undet_w += 32'(len);
        default: begin
          valid_w   += 32'(len);
          valid_sum += 32'(len) * 32'(smp);
        end
      endcase
    endfunction

    // Decide the current bin, keep it if the run limit allows, move to the next bin
    function void close_bin(longint unsigned r);
      resampled_bin_t       b;
      logic [RBR_SMP_W-1:0] v;
      longint unsigned      num, den, m;
      if (undet_w > valid_w && undet_w >= nodata_w) begin
        v = undetect_code;
      end else if (nodata_w > valid_w && nodata_w > undet_w) begin
        v = nodata_code;
      end else if (valid_w == 0) begin
        v = nodata_code;
      end else begin
        num = valid_sum;
        den = valid_w;
        m = (2 * num + den) / (2 * den);
        if (m < VAL_MIN) m = VAL_MIN;
        if (m > VAL_MAX) m = VAL_MAX;
        v = 16'(m);
      end
      if (run_count < RBR_MAX_RUN) begin
        b.value    = v;
        b.ray_end  = run_closes_ray && (ray_bin_count + 1 == run_target);
        b.run_last = 1'b0;
        b.dropped  = 1'b0;
        run_q.push_back(b);
      end else begin
        run_drop = 1'b1;
      end
      run_count++;
      clear_weights();
      bin_start += r;
      ray_bin_count++;
    endfunction

    // Called on every accepted input transfer
    function void note_sample(logic [RBR_SMP_W-1:0] smp, logic last);
      longint unsigned len_in, r, c, e, lo, hi, from;
      rbr_cls_t        cls;
      len_in = (in_len == 0) ? 1 : in_len;
      r      = (out_len == 0) ? 1 : out_len;
      c      = ray_pos;
      e      = c + len_in;
      if (smp == nodata_code) cls = CLS_NODATA;
      else if (smp == undetect_code) cls = CLS_UNDET;
      else cls = CLS_VALID;
      run_count      = 0;
      run_drop       = 1'b0;
      run_closes_ray = last || (samples_in_ray + 1 >= RBR_MAX_RAY_BINS);
      run_target     = run_closes_ray ? (2 * e + r) / (2 * r) : 0;

      // bins that this sample completes
      while (bin_start + r <= e) begin
        hi = bin_start + r;
        lo = (c > bin_start) ? c : bin_start;
        if (hi > lo) add_weight(cls, smp, hi - lo);
        close_bin(r);
      end
      lo = (c > bin_start) ? c : bin_start;
      if (e > lo) add_weight(cls, smp, e - lo);
      ray_pos = e;
      samples_in_ray++;

      // ray end: pad out to the rounded bin count, the part past the end is nodata
      if (run_closes_ray) begin
        while (ray_bin_count < run_target && run_count <= RBR_MAX_RUN) begin
          from = (bin_start > e) ? bin_start : e;
          nodata_w += 32'(bin_start + r - from);
          close_bin(r);
        end
        if (ray_bin_count < run_target) run_drop = 1'b1;
        clear_ray();
      end

      foreach (run_q[k]) begin
        run_q[k].dropped  = run_drop;
        run_q[k].run_last = (k == run_q.size() - 1);
        expected_q.push_back(run_q[k]);
      end
      run_q.delete();
    endfunction

    // Called on every accepted result transfer
    function void check_result(logic [RBR_SMP_W-1:0] value, logic ray_end, logic run_last,
                               logic dropped);
      resampled_bin_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: value=%0d end=%0b last=%0b drop=%0b",
                   $time, value, ray_end, run_last, dropped);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (value !== want.value || ray_end !== want.ray_end || run_last !== want.run_last ||
          dropped !== want.dropped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] bin %0d: expected value=%0d end=%0b last=%0b drop=%0b",
                   $time, results_checked, want.value, want.ray_end, want.run_last,
                   want.dropped);
          $display("[%0t] bin %0d:      got value=%0d end=%0b last=%0b drop=%0b",
                   $time, results_checked, value, ray_end, run_last, dropped);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [RBR_CFG_AW-1:0] cfg_idx;
  logic [RBR_CFG_W-1:0]  cfg_data;

  rbr_in_if  smp_bus ();
  rbr_out_if res_bus ();

  resample_scoreboard sb = new();

  int          src_idle_pct     = 0;
  int          snk_stall_pct    = 0;
  bit          hold_off         = 1'b0;
  int unsigned items_sent       = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count      = 0;

  range_bin_resampler_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .smp_ch   (smp_bus),
    .res_ch   (res_bus)
  );

  // Clock
  always #CLK_HALF clk = ~clk;

  // Result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.value, res_bus.ray_end, res_bus.run_last, res_bus.dropped);
    res_bus.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("range_bin_resampler_unit test failed");
    $finish;
  end

  // Write all four registers, one per cycle
  task automatic apply_setting(input logic [RBR_CFG_W-1:0] nd, input logic [RBR_CFG_W-1:0] ud,
                               input logic [RBR_CFG_W-1:0] il, input logic [RBR_CFG_W-1:0] ol);
    logic [RBR_CFG_W-1:0] vals[4];
    vals = '{nd, ud, il, ol};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_ORDER[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Offer one sample, with a random gap first, and hold it until the transfer
  task automatic send_sample(input logic [RBR_SMP_W-1:0] smp, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      smp_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    smp_bus.valid       <= 1'b1;
    smp_bus.sample      <= smp;
    smp_bus.last_in_ray <= last;
    do @(posedge clk); while (!smp_bus.ready);
    sb.note_sample(smp, last);
    items_sent++;
  endtask

  task automatic stop_sending();
    smp_bus.valid <= 1'b0;
  endtask

  // Wait for every owed bin, then let any result-free work finish
  task automatic wait_idle();
    while (sb.pending()) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random lengths kept within a few bins per sample, codes sometimes equal
  task automatic random_setting();
    logic [RBR_CFG_W-1:0] nd, ud, il, ol;
    nd = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom());
    case ($urandom_range(3))
      0:       ud = 16'h0000;
      1:       ud = nd;
      default: ud = 16'($urandom());
    endcase
    il = 16'($urandom_range(1, 3000));
    case ($urandom_range(3))
      0:       ol = il;
      1:       ol = 16'(il * $urandom_range(2, 4));
      2:       ol = 16'(il / $urandom_range(2, 8) + 1);
      default: ol = 16'($urandom_range(il / 8 + 1, il + 4000));
    endcase
    apply_setting(nd, ud, il, ol);
  endtask

  // Flavor biases a ray toward valid, nodata, undetect or a mix
  function automatic logic [RBR_SMP_W-1:0] random_sample(int flavor);
    int roll;
    int nd_pct;
    int ud_pct;
    roll   = $urandom_range(99);
    nd_pct = (flavor == 1) ? 60 : (flavor == 3) ? 30 : (flavor == 2) ? 10 : 5;
    ud_pct = (flavor == 2) ? 60 : (flavor == 3) ? 30 : (flavor == 1) ? 10 : 5;
    if (roll < nd_pct) return sb.nodata_code;
    if (roll < nd_pct + ud_pct) return sb.undetect_code;
    if (roll < nd_pct + ud_pct + 6) return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
    return 16'($urandom());
  endfunction

  // Stimulus
  initial begin
    int ray_len;
    int flavor;
    int seg_items;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_NODATA;
    cfg_data            = '0;
    smp_bus.valid       = 1'b0;
    smp_bus.sample      = '0;
    smp_bus.last_in_ray = 1'b0;
    res_bus.ready       = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Reset values: plain mean, undetect winning a tie, nodata majority,
    // and a last sample whose rounded bin count was already reached
    send_sample(16'd1000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd3000, 1'b0);
    send_sample(16'd4000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd11, 1'b1);
    stop_sending();
    wait_idle();

    // Equal codes, widest lengths, clamp at the top
    apply_setting(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b1);
    stop_sending();
    wait_idle();

    // Zero lengths act as one meter; a valid zero clamps to the bottom
    apply_setting(16'd100, 16'd200, 16'h0000, 16'h0000);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    stop_sending();
    wait_idle();

    // Per-input limit overflow, ray end bin lost with the dropped ones
    apply_setting(16'hFFFF, 16'h0000, 16'd2000, 16'd40);
    send_sample(16'd500, 1'b0);
    send_sample(16'd501, 1'b1);
    stop_sending();
    wait_idle();

    // Ray too short for even one rounded bin
    apply_setting(16'hA5A5, 16'h5A5A, 16'd1, 16'hFFFF);
    send_sample(16'd9, 1'b1);
    stop_sending();
    wait_idle();

    // Output length changed in the middle of a ray, tail past the ray end
    apply_setting(16'hFFFF, 16'h0000, 16'd300, 16'd1000);
    send_sample(16'd800, 1'b0);
    send_sample(16'd900, 1'b0);
    stop_sending();
    wait_idle();
    apply_setting(16'hFFFF, 16'h0000, 16'd300, 16'd250);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1100, 1'b1);
    stop_sending();
    wait_idle();

    // Random rays under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  <= SRC_IDLE[ph];
      snk_stall_pct <= SNK_STALL[ph];
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            repeat (30) @(posedge clk);
            hold_off <= 1'b1;
            repeat (500) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int seg = 0; seg < 4; seg++) begin
        random_setting();
        seg_items = 0;
        while (seg_items < SEG_ITEMS) begin
          ray_len = $urandom_range(1, 12);
          flavor  = $urandom_range(3);
          for (int k = 0; k < ray_len; k++)
            send_sample(random_sample(flavor), k == ray_len - 1);
          seg_items += ray_len;
        end
        stop_sending();
        wait_idle();
      end
    end

    $display("Sent %0d samples and checked %0d output bins over %0d register settings,",
             items_sent, sb.results_checked, settings_applied);
    $display("with idle and stall phases and a long receiver hold-off; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("range_bin_resampler_unit test passed");
    end else begin
      $display("range_bin_resampler_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rbr_pkg.sv
rtl/rbr_in_if.sv
rtl/rbr_out_if.sv
rtl/rbr_div.sv
rtl/rbr_buf.sv
rtl/range_bin_resampler_unit.sv
tb/tb_range_bin_resampler_unit.sv
